>>> hw/rtl/rgba_mip_downsample_2x2_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the mip downsampler RTL
// Each macro is one clocked property, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef RGBA_MIP_DOWNSAMPLE_2X2_MACROS_SVH
`define RGBA_MIP_DOWNSAMPLE_2X2_MACROS_SVH

// Same-cycle implication: when ANTE holds, CONS holds on that edge.
`define RMD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rmd assertion failed: same-cycle implication");

// Next-cycle implication: when ANTE holds, CONS holds on the following edge.
`define RMD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rmd assertion failed: next-cycle implication");

`endif

>>> hw/rtl/rmd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmd_pkg
// Types and fixed constants of the 2x2 RGBA mip downsampler.
// ----------------------------------------------------------------------------
package rmd_pkg;

   localparam int CSR_DATA_W = 13;
   localparam int HEIGHT_W   = 12;
   localparam int MAX_HEIGHT = 4096;
   localparam int PAIR_W     = 10;

   typedef logic [1:0] csr_index_type;
   localparam csr_index_type CSR_SRC_WIDTH  = 2'd0;
   localparam csr_index_type CSR_SRC_HEIGHT = 2'd1;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
   } pixel_type;

   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic [7:0] out_alpha;
      logic       frame_last;
   } result_type;

   // Four horizontal pair sums, channel 0 is red.
   typedef logic [3:0][PAIR_W-1:0] pair_quad_type;

endpackage

>>> hw/rtl/rmd_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmd_req_if
// Valid/ready channel carrying one source pixel per word.
// ----------------------------------------------------------------------------
interface rmd_req_if
   import rmd_pkg::*;
();
   logic      valid;
   logic      ready;
   pixel_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> hw/rtl/rmd_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmd_rsp_if
// Valid/ready channel carrying one downsampled pixel per word.
// ----------------------------------------------------------------------------
interface rmd_rsp_if
   import rmd_pkg::*;
();
   logic       valid;
   logic       ready;
   result_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> hw/rtl/rgba_mip_downsample_2x2.sv
`timescale 1ns / 1ps
`include "rgba_mip_downsample_2x2_macros.svh"
// ----------------------------------------------------------------------------
// rgba_mip_downsample_2x2
// 2x2 box-filter mip downsampler for raster-order RGBA8 pixel streams.
//
// Usage:
//   req_chan carries source pixels in raster order, one word per pixel.
//   rsp_chan carries the pixels of the next mip level, with frame_last set
//   on the final pixel of each output frame. csr_* sets src_width and
//   src_height; a size write restarts the frame at the top left corner.
//   Throughput is one source pixel per cycle while rsp_chan accepts results.
//   The source pixel that completes a 2x2 block passes the line store read
//   and read stage registers, then the output register, before its result
//   word appears on rsp_chan. The line store is a single memory of
//   MAX_WIDTH/2 entries with one write and one registered read port; the
//   even row writes a slot and the odd row reads it back.
//   Reset clears position, held pixel and sizes (1x1); the line store is
//   not cleared, every slot is written before it is read.
//   When rsp_chan stalls, the output register and the read stage hold and
//   req_chan.ready drops once both are full; words that produce no result
//   still need a free read stage to be taken.
// ----------------------------------------------------------------------------
module rgba_mip_downsample_2x2
   import rmd_pkg::*;
#(
   parameter int MAX_WIDTH = 4096
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  csr_index_type         csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   rmd_req_if.sink               req_chan,
   rmd_rsp_if.source             rsp_chan
);

   localparam int STORE_DEPTH = MAX_WIDTH / 2;
   localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int X_W         = $clog2(MAX_WIDTH);
   localparam int CMPW_W      = CSR_DATA_W + $clog2(MAX_WIDTH + 1);
   localparam int CMPH_W      = CSR_DATA_W + 1;

   // ------------------------------------------------------------------
   // Size registers: hold last index, last used index and size-one flag
   // ------------------------------------------------------------------
   logic [X_W-1:0]      w_last_ff, w_last_in;
   logic [X_W-1:0]      w_ulast_ff, w_ulast_in;
   logic                w_one_ff, w_one_in;
   logic [HEIGHT_W-1:0] h_last_ff, h_last_in;
   logic [HEIGHT_W-1:0] h_ulast_ff, h_ulast_in;
   logic                h_one_ff, h_one_in;
   logic [CMPW_W-1:0]   w_raw, w_eff;
   logic [CMPH_W-1:0]   h_raw, h_eff;
   logic                cfg_w_wr, cfg_h_wr, cfg_restart;

   assign cfg_w_wr    = csr_we && (csr_index == CSR_SRC_WIDTH);
   assign cfg_h_wr    = csr_we && (csr_index == CSR_SRC_HEIGHT);
   assign cfg_restart = cfg_w_wr || cfg_h_wr;

   always_comb begin
      // Zero acts as one, oversize clamps to the maximum.
      w_raw = CMPW_W'(csr_wdata);
      if (w_raw == '0) begin
         w_eff = CMPW_W'(1);
      end else if (w_raw > CMPW_W'(MAX_WIDTH)) begin
         w_eff = CMPW_W'(MAX_WIDTH);
      end else begin
         w_eff = w_raw;
      end
      h_raw = CMPH_W'(csr_wdata);
      if (h_raw == '0) begin
         h_eff = CMPH_W'(1);
      end else if (h_raw > CMPH_W'(MAX_HEIGHT)) begin
         h_eff = CMPH_W'(MAX_HEIGHT);
      end else begin
         h_eff = h_raw;
      end
      w_one_in   = (w_eff == CMPW_W'(1));
      h_one_in   = (h_eff == CMPH_W'(1));
      w_last_in  = X_W'(w_eff - CMPW_W'(1));
      h_last_in  = HEIGHT_W'(h_eff - CMPH_W'(1));
      // Drop the trailing odd column or row unless the size is one.
      w_ulast_in = w_one_in ? '0 : X_W'((w_eff & ~CMPW_W'(1)) - CMPW_W'(1));
      h_ulast_in = h_one_in ? '0 : HEIGHT_W'((h_eff & ~CMPH_W'(1)) - CMPH_W'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_last_ff  <= '0;
         w_ulast_ff <= '0;
         w_one_ff   <= 1'b1;
         h_last_ff  <= '0;
         h_ulast_ff <= '0;
         h_one_ff   <= 1'b1;
      end else begin
         if (cfg_w_wr) begin
            w_last_ff  <= w_last_in;
            w_ulast_ff <= w_ulast_in;
            w_one_ff   <= w_one_in;
         end
         if (cfg_h_wr) begin
            h_last_ff  <= h_last_in;
            h_ulast_ff <= h_ulast_in;
            h_one_ff   <= h_one_in;
         end
      end
   end

   // ------------------------------------------------------------------
   // Handshake and pipeline enables
   // ------------------------------------------------------------------
   logic       rsp_valid_ff;
   result_type rsp_data_ff;
   logic       s1_valid_ff;
   logic       out_en, s1_en, req_fire;

   assign out_en         = !rsp_valid_ff || rsp_chan.ready;
   assign s1_en          = !s1_valid_ff || out_en;
   assign req_chan.ready = s1_en;
   assign req_fire       = req_chan.valid && s1_en;

   // ------------------------------------------------------------------
   // Source position and pixel classification
   // ------------------------------------------------------------------
   logic [X_W-1:0]      x_ff, x_in;
   logic [HEIGHT_W-1:0] y_ff, y_in;
   pixel_type           held_ff;
   logic                x_last, y_last, in_area, pair_ok;
   logic                store_wr, store_rd, produce;
   logic [ADDR_W-1:0]   slot;
   pair_quad_type       hsum;
   logic [3:0][7:0]     px, held;

   assign x_last  = (x_ff == w_last_ff);
   assign y_last  = (y_ff == h_last_ff);
   assign in_area = (x_ff <= w_ulast_ff) && (y_ff <= h_ulast_ff);
   // A horizontal pair is complete on odd columns, or on every pixel of a
   // one-wide image where the pixel pairs with itself.
   assign pair_ok = in_area && (w_one_ff || x_ff[0]);

   assign store_wr = req_fire && pair_ok && !h_one_ff && !y_ff[0];
   assign store_rd = req_fire && pair_ok && !h_one_ff && y_ff[0];
   assign produce  = req_fire && pair_ok && (h_one_ff || y_ff[0]);
   assign slot     = ADDR_W'(x_ff >> 1);

   assign px   = {req_chan.payload.alpha, req_chan.payload.blue,
                  req_chan.payload.green, req_chan.payload.red};
   assign held = {held_ff.alpha, held_ff.blue, held_ff.green, held_ff.red};

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         if (w_one_ff) begin
            hsum[c] = {1'b0, px[c], 1'b0};
         end else begin
            hsum[c] = PAIR_W'(held[c]) + PAIR_W'(px[c]);
         end
      end
   end

   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      if (x_last) begin
         x_in = '0;
         y_in = y_last ? '0 : y_ff + HEIGHT_W'(1);
      end else begin
         x_in = x_ff + X_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff <= '0;
         y_ff <= '0;
      end else if (cfg_restart) begin
         x_ff <= '0;
         y_ff <= '0;
      end else if (req_fire) begin
         x_ff <= x_in;
         y_ff <= y_in;
      end
   end

   // Hold the even-column pixel until its partner arrives.
   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
      end else if (req_fire && in_area && !w_one_ff && !x_ff[0]) begin
         held_ff <= req_chan.payload;
      end
   end

   // ------------------------------------------------------------------
   // Line store: even rows write pair sums, odd rows read them back
   // ------------------------------------------------------------------
   pair_quad_type store_mem [STORE_DEPTH];
   pair_quad_type rd_ff;

   always_ff @(posedge clock) begin
      if (store_wr) begin
         store_mem[slot] <= hsum;
      end
   end

   always_ff @(posedge clock) begin
      if (store_rd) begin
         rd_ff <= store_mem[slot];
      end
   end

   // ------------------------------------------------------------------
   // Read stage: carry the pair sum alongside the store read
   // ------------------------------------------------------------------
   pair_quad_type s1_hsum_ff;
   logic          s1_store_ff;
   logic          s1_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_en) begin
         s1_valid_ff <= produce;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_en && produce) begin
         s1_hsum_ff  <= hsum;
         s1_store_ff <= !h_one_ff;
         s1_last_ff  <= (x_ff == w_ulast_ff) && (y_ff == h_ulast_ff);
      end
   end

   // ------------------------------------------------------------------
   // Output stage: add vertical pair, divide by four, register
   // ------------------------------------------------------------------
   logic [3:0][PAIR_W-1:0] total;
   result_type             result;

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         if (s1_store_ff) begin
            total[c] = rd_ff[c] + s1_hsum_ff[c];
         end else begin
            total[c] = {s1_hsum_ff[c][PAIR_W-2:0], 1'b0};
         end
      end
      result.out_red    = total[0][PAIR_W-1:2];
      result.out_green  = total[1][PAIR_W-1:2];
      result.out_blue   = total[2][PAIR_W-1:2];
      result.out_alpha  = total[3][PAIR_W-1:2];
      result.frame_last = s1_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_en) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_en && s1_valid_ff) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   `RMD_ASSERT_NOW(a_stall_blocks_req, clock, reset,
      s1_valid_ff && rsp_valid_ff && !rsp_chan.ready, !req_chan.ready)
   `RMD_ASSERT_NEXT(a_read_feeds_stage, clock, reset,
      store_rd, s1_valid_ff && s1_store_ff)
   `RMD_ASSERT_NEXT(a_frame_wraps, clock, reset,
      req_fire && x_last && y_last && !cfg_restart, x_ff == '0 && y_ff == '0)
   `RMD_ASSERT_NEXT(a_cfg_restarts, clock, reset,
      cfg_restart, x_ff == '0 && y_ff == '0)

endmodule

>>> tb/rmd_mip_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmd_mip_checker
// Follows the size writes and every accepted source word, predicts the words
// of the next mip level and compares each result word in order, field by
// field. Hands the mismatch count and the number of outstanding words upward.
// ----------------------------------------------------------------------------
module rmd_mip_checker
   import rmd_pkg::*;
#(
   parameter int MAX_WIDTH = 4096
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  csr_index_type         csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   rmd_req_if                    req_mon,
   rmd_rsp_if                    rsp_mon,
   output int                    error_count,
   output int                    pending_count
);

   localparam int SLOTS = MAX_WIDTH / 2;

   pair_quad_type         row_pair_sums [SLOTS];
   pixel_type             held_pixel;
   int unsigned           col_pos;
   int unsigned           row_pos;
   logic [CSR_DATA_W-1:0] width_reg;
   logic [CSR_DATA_W-1:0] height_reg;
   result_type            mip_expected [$];
   int                    mismatches = 0;

   // Zero counts as one, anything past the limit counts as the limit.
   function automatic int unsigned clamp_dim(input logic [CSR_DATA_W-1:0] v,
                                             input int unsigned limit);
      if (v == 0)
         return 1;
      if (v > limit)
         return limit;
      return v;
   endfunction

   function automatic int field_diff(input string name, input logic [7:0] want,
                                     input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         return 1;
      end
      return 0;
   endfunction

   task automatic predict_downsample(input pixel_type p);
      int unsigned sw;
      int unsigned sh;
      int unsigned dw;
      int unsigned dh;
      int unsigned used_w;
      int unsigned used_h;
      int unsigned slot;
      int unsigned px    [4];
      int unsigned near  [4];
      int unsigned hsum  [4];
      int unsigned total [4];
      bit          have_pair;
      bit          produced;
      result_type  r;
      sw     = clamp_dim(width_reg, MAX_WIDTH);
      sh     = clamp_dim(height_reg, MAX_HEIGHT);
      dw     = (sw == 1) ? 1 : sw / 2;
      dh     = (sh == 1) ? 1 : sh / 2;
      used_w = (sw == 1) ? 1 : dw * 2;
      used_h = (sh == 1) ? 1 : dh * 2;
      px     = '{p.red, p.green, p.blue, p.alpha};
      near   = '{held_pixel.red, held_pixel.green, held_pixel.blue, held_pixel.alpha};
      produced = 1'b0;
      if (col_pos < used_w && row_pos < used_h) begin
         have_pair = 1'b1;
         slot      = (col_pos / 2) % SLOTS;
         if (sw == 1) begin
            foreach (hsum[c]) hsum[c] = px[c] * 2;
         end else if (col_pos % 2 == 0) begin
            held_pixel = p;
            have_pair  = 1'b0;
         end else begin
            foreach (hsum[c]) hsum[c] = near[c] + px[c];
         end
         if (have_pair) begin
            if (sh == 1) begin
               foreach (total[c]) total[c] = hsum[c] * 2;
               produced = 1'b1;
            end else if (row_pos % 2 == 0) begin
               for (int c = 0; c < 4; c++) row_pair_sums[slot][c] = PAIR_W'(hsum[c]);
            end else begin
               for (int c = 0; c < 4; c++) total[c] = row_pair_sums[slot][c] + hsum[c];
               produced = 1'b1;
            end
         end
      end
      if (produced) begin
         r.out_red    = 8'(total[0] >> 2);
         r.out_green  = 8'(total[1] >> 2);
         r.out_blue   = 8'(total[2] >> 2);
         r.out_alpha  = 8'(total[3] >> 2);
         r.frame_last = (col_pos / 2 == dw - 1) && (row_pos / 2 == dh - 1);
         mip_expected = {mip_expected, r};
      end
      if (col_pos + 1 >= sw) begin
         col_pos = 0;
         row_pos = (row_pos + 1 >= sh) ? 0 : row_pos + 1;
      end else begin
         col_pos++;
      end
   endtask

   task automatic check_result(input result_type got);
      result_type want;
      if (mip_expected.size() == 0) begin
         $display("%0t: result word %h with none expected", $time, got);
         mismatches++;
      end else begin
         want = mip_expected.pop_front();
         mismatches += field_diff("out_red", want.out_red, got.out_red);
         mismatches += field_diff("out_green", want.out_green, got.out_green);
         mismatches += field_diff("out_blue", want.out_blue, got.out_blue);
         mismatches += field_diff("out_alpha", want.out_alpha, got.out_alpha);
         mismatches += field_diff("frame_last", want.frame_last, got.frame_last);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         held_pixel = '0;
         col_pos    = 0;
         row_pos    = 0;
         width_reg  = 1;
         height_reg = 1;
         mip_expected.delete();
      end else begin
         // A size write restarts the frame; other indexes are ignored.
         if (csr_we && csr_index == CSR_SRC_WIDTH) begin
            width_reg = csr_wdata;
            col_pos   = 0;
            row_pos   = 0;
         end else if (csr_we && csr_index == CSR_SRC_HEIGHT) begin
            height_reg = csr_wdata;
            col_pos    = 0;
            row_pos    = 0;
         end
         if (req_mon.valid && req_mon.ready)
            predict_downsample(req_mon.payload);
         if (rsp_mon.valid && rsp_mon.ready)
            check_result(rsp_mon.payload);
      end
      error_count   <= mismatches;
      pending_count <= mip_expected.size();
   end

endmodule

>>> tb/tb_rgba_mip_downsample_2x2.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rgba_mip_downsample_2x2
// Drives source pixel streams through the 2x2 mip downsampler across many
// frame sizes and lets the checker beside the block judge every result word.
// A short hand-picked opening covers the clamped 1x1 sizes, truncation,
// frame wrap and odd sizes; random frames follow, then a few frames at the
// largest sizes. Both channels idle at random, with one clean stretch,
// long receiver hold-offs and sender pauses that let the block drain.
// ----------------------------------------------------------------------------
module tb_rgba_mip_downsample_2x2;
   import rmd_pkg::*;

   localparam int RANDOM_ITEMS   = 850;
   localparam int HOLDOFF_CYCLES = 80;
   localparam int DRAIN_CYCLES   = 6;
   localparam int WATCHDOG_LIMIT = 2000;

   // Indexes past the register list: writes there must change nothing.
   localparam csr_index_type CSR_SPARE_A = 2'd2;
   localparam csr_index_type CSR_SPARE_B = 2'd3;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   csr_index_type         csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   rmd_req_if req_chan ();
   rmd_rsp_if rsp_chan ();

   int error_count;
   int pending_count;
   bit tx_idle_on       = 1'b1;
   bit rx_idle_on       = 1'b1;
   int holdoff_requests = 0;

   rgba_mip_downsample_2x2 dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan)
   );

   rmd_mip_checker mip_check (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Result side: drop ready at random, or hold it low for a whole hold-off
   // when the stimulus asks for one. Requests are counted so that none is
   // lost to the order of processes at an edge.
   initial begin
      int served;
      int hold_left;
      served    = 0;
      hold_left = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left == 0 && served != holdoff_requests) begin
            served++;
            hold_left = HOLDOFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (rx_idle_on) begin
            rsp_chan.ready <= ($urandom_range(99) >= 24);
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Watchdog: end the run once nothing has moved on either channel for too
   // long; the longest legal quiet spell is the receiver hold-off.
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("tb_rgba_mip_downsample_2x2: done, errors");
      $finish;
   end

   // Register size as written, reduced to what the block acts on.
   function automatic int unsigned frame_dim(input logic [CSR_DATA_W-1:0] v);
      if (v == 0)
         return 1;
      if (v > MAX_HEIGHT)
         return MAX_HEIGHT;
      return v;
   endfunction

   // Lean on the channel extremes now and then.
   function automatic logic [7:0] draw_channel();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 8)
         return 8'h00;
      if (roll < 16)
         return 8'hFF;
      return 8'($urandom);
   endfunction

   // Mostly small sizes, a zero now and then, a few wider ones.
   function automatic logic [CSR_DATA_W-1:0] draw_dim();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 8)
         return '0;
      if (roll < 70)
         return CSR_DATA_W'($urandom_range(1, 8));
      if (roll < 90)
         return CSR_DATA_W'($urandom_range(9, 24));
      return CSR_DATA_W'($urandom_range(25, 64));
   endfunction

   // Offer one word, with an optional idle cycle first, and hold it until
   // the block takes it.
   task automatic send_pixel(input pixel_type p);
      if (tx_idle_on && $urandom_range(99) < 32) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.payload <= p;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
   endtask

   // Stop offering, wait for every outstanding result word, then give the
   // pipeline time to swallow words that produce nothing.
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic program_frame_size(input logic [CSR_DATA_W-1:0] w,
                                     input logic [CSR_DATA_W-1:0] h);
      csr_we    <= 1'b1;
      csr_index <= CSR_SRC_WIDTH;
      csr_wdata <= w;
      @(posedge clock);
      csr_index <= CSR_SRC_HEIGHT;
      csr_wdata <= h;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic write_unmapped();
      csr_we    <= 1'b1;
      csr_index <= $urandom_range(1) ? CSR_SPARE_A : CSR_SPARE_B;
      csr_wdata <= CSR_DATA_W'($urandom);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Stream random pixels; optionally start a receiver hold-off, or drain and
   // poke an unmapped register in mid-frame, at the given word number.
   task automatic stream_pixels(input int count, input int holdoff_at, input int pause_at);
      pixel_type p;
      for (int i = 0; i < count; i++) begin
         if (i == holdoff_at)
            holdoff_requests <= holdoff_requests + 1;
         if (i == pause_at) begin
            wait_drained();
            write_unmapped();
         end
         p.red   = draw_channel();
         p.green = draw_channel();
         p.blue  = draw_channel();
         p.alpha = draw_channel();
         send_pixel(p);
      end
   endtask

   initial begin
      int                    sent;
      int                    phase;
      int                    count;
      int                    area;
      logic [CSR_DATA_W-1:0] w;
      logic [CSR_DATA_W-1:0] h;

      reset            <= 1'b1;
      csr_we           <= 1'b0;
      csr_index        <= CSR_SRC_WIDTH;
      csr_wdata        <= '0;
      req_chan.valid   <= 1'b0;
      req_chan.payload <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset size is 1x1: each pixel passes through and ends the frame.
      send_pixel('{8'h00, 8'hFF, 8'h80, 8'h7F});
      wait_drained();

      // Zero sizes act as one.
      program_frame_size('0, '0);
      send_pixel('{8'hFF, 8'h00, 8'h01, 8'hFE});
      wait_drained();

      // One 2x2 block with truncating sums, then a second frame of all ones
      // to check the wrap back to the top left corner.
      program_frame_size(2, 2);
      send_pixel('{8'd255, 8'd0, 8'd1, 8'd255});
      send_pixel('{8'd255, 8'd0, 8'd2, 8'd0});
      send_pixel('{8'd255, 8'd0, 8'd3, 8'd255});
      send_pixel('{8'd254, 8'd3, 8'd4, 8'd0});
      repeat (4) send_pixel('{8'hFF, 8'hFF, 8'hFF, 8'hFF});
      wait_drained();

      // 3x3 drops the trailing column and row; a write to an unmapped index
      // in mid-frame must leave the position alone.
      program_frame_size(3, 3);
      stream_pixels(9, -1, 3);

      // Random frames. Phase 1 runs clean on both sides, every fourth phase
      // from phase 2 holds the receiver off while the sender keeps pushing,
      // and every fourth phase from phase 3 drains in mid-frame.
      sent  = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         w     = draw_dim();
         h     = draw_dim();
         area  = frame_dim(w) * frame_dim(h);
         count = area * $urandom_range(1, 3) + $urandom_range(0, area - 1);
         if (count > 240)
            count = 240;
         if (phase == 1 && count < 150)
            count = 150;
         if (phase % 4 == 2 && count < 40)
            count = 40;
         wait_drained();
         program_frame_size(w, h);
         tx_idle_on = (phase != 1 && phase % 4 != 2);
         rx_idle_on <= (phase != 1);
         stream_pixels(count, (phase % 4 == 2) ? 8 : -1,
                       (phase % 4 == 3) ? count / 2 : -1);
         sent += count;
         phase++;
      end
      tx_idle_on = 1'b1;
      rx_idle_on <= 1'b1;

      // Largest sizes. An oversize width acts as the maximum; on a one-row
      // frame every second word completes a block, so a hold-off there fills
      // the block while the sender keeps offering. An oversize height acts
      // as the maximum.
      wait_drained();
      program_frame_size('1, 1);
      stream_pixels(120, 30, -1);
      wait_drained();
      program_frame_size(1, '1);
      stream_pixels(100, -1, 50);
      wait_drained();
      program_frame_size(3, '1);
      stream_pixels(60, -1, -1);

      wait_drained();
      if (error_count == 0 && pending_count == 0)
         $display("tb_rgba_mip_downsample_2x2: done, clean");
      else
         $display("tb_rgba_mip_downsample_2x2: done, errors");
      $finish;
   end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/rmd_pkg.sv
hw/rtl/rmd_req_if.sv
hw/rtl/rmd_rsp_if.sv
hw/rtl/rgba_mip_downsample_2x2.sv
tb/rmd_mip_checker.sv
tb/tb_rgba_mip_downsample_2x2.sv
